@@ rtl/core/dmadc_pkg.sv @@
`default_nettype none
package dmadc_pkg;

  // Bus operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register map of the bus side
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_COUNT    = 3'd1;
  localparam logic [2:0] REG_SECTOR   = 3'd2;
  localparam logic [2:0] REG_DMA      = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_BASE     = 2'd1;
  localparam logic [1:0] CFG_SEEK     = 2'd2;

  // Transfer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_XFER  = 2'd2;

  localparam int unsigned WordBytes = 4;
  localparam int unsigned ProdWidth = 48;
  localparam int unsigned DivSteps  = ProdWidth;
  localparam int unsigned CntWidth  = $clog2(DivSteps);

  localparam logic [31:0] BaseDelayReset  = 32'd100;
  localparam logic [31:0] SeekFactorReset = 32'd1000;

  typedef struct packed {
    logic step;      // apply the accepted request and load the output register
    logic mul;       // form distance times seek factor
    logic div_step;  // one restoring division step
    logic fin;       // load the seek delay and enter the delay phase
  } cmd_t;

  typedef struct packed {
    logic seek_req;  // accepted request is a start that needs a seek delay
  } status_t;

endpackage
`default_nettype wire

@@ rtl/core/dmadc_ctrl.sv @@
`default_nettype none
module dmadc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire dmadc_pkg::status_t status_i,
  output dmadc_pkg::cmd_t       cmd_o
);
  import dmadc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                ovalid_q, ovalid_d;
  logic                accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    ovalid_d = ovalid_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.step = 1'b1;
          ovalid_d   = 1'b1;
          if (status_i.seek_req) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(DivSteps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dmadc_dp.sv @@
`default_nettype none
module dmadc_dp #(
  parameter int unsigned SECTOR_WORDS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [2:0]        register_index_i,
  input  wire logic [31:0]       write_data_i,
  input  wire dmadc_pkg::cmd_t   cmd_i,
  output dmadc_pkg::status_t     status_o,
  output logic [31:0]            read_data_o,
  output logic                   bus_error_o,
  output logic                   move_valid_o,
  output logic                   move_to_disk_o,
  output logic [31:0]            memory_address_o,
  output logic [31:0]            disk_sector_o,
  output logic [6:0]             word_in_sector_o,
  output logic                   interrupt_pulse_o
);
  import dmadc_pkg::*;

  localparam int unsigned WW = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;

  // Configuration
  logic [31:0] cap_q;
  logic [15:0] base_q, seek_q;

  // Controller state
  logic        wm_q, wm_d, ien_q, ien_d, err_q, err_d, busy_q, busy_d;
  logic [31:0] count_q, count_d, cur_q, cur_d, dma_q, dma_d, prev_q, prev_d;
  logic [31:0] delay_q, delay_d, sl_q, sl_d, run_q, run_d;
  logic [1:0]  phase_q, phase_d;
  logic [WW-1:0] words_q, words_d;

  // Seek delay unit
  logic [ProdWidth-1:0] dvd_q;
  logic [31:0]          rem_q;
  logic [32:0]          trial, diff;
  logic [31:0]          span;
  logic [ProdWidth:0]   dsum;

  // Result
  logic [31:0] rd_d;
  logic        be_d, mv_d, md_d, ip_d;
  logic [31:0] ma_d, ds_d;
  logic [6:0]  wi_d;

  logic          locked, start, range_bad, eff_start;
  logic [31:0]   eff_sl, eff_run, words32;
  logic [WW-1:0] eff_words;
  logic [32:0]   end_sum;

  assign locked  = (phase_q == PH_XFER);
  assign start   = (operation_i == OP_WRITE) && (register_index_i == REG_CTRL) && !locked
                   && write_data_i[0];
  assign status_o.seek_req = start && (cap_q != '0);

  assign end_sum   = {1'b0, cur_q} + {1'b0, count_q};
  assign range_bad = (cap_q == '0) || (count_q == '0) || (cur_q >= cap_q)
                     || (end_sum > {1'b0, cap_q});

  always_comb begin
    wm_d = wm_q; ien_d = ien_q; err_d = err_q; busy_d = busy_q;
    count_d = count_q; cur_d = cur_q; dma_d = dma_q; prev_d = prev_q;
    delay_d = delay_q; sl_d = sl_q; run_d = run_q; phase_d = phase_q;
    words_d = words_q;
    rd_d = '0; be_d = 1'b0; mv_d = 1'b0; md_d = 1'b0; ip_d = 1'b0;
    ma_d = '0; ds_d = '0; wi_d = '0;
    eff_start = 1'b0;
    eff_sl = sl_q; eff_run = run_q; eff_words = words_q;
    words32 = '0;
    case (operation_i)
      OP_READ: begin
        if (register_index_i == REG_CTRL) begin
          rd_d = {27'd0, busy_q, err_q, wm_q, ien_q, 1'b0};
        end else if (register_index_i == REG_CAPACITY) begin
          rd_d = cap_q;
        end else begin
          be_d = 1'b1;
        end
      end
      OP_WRITE: begin
        case (register_index_i)
          REG_CTRL: begin
            if (!locked) begin
              wm_d  = write_data_i[2];
              ien_d = write_data_i[1];
              if (write_data_i[0]) begin
                busy_d = 1'b1;
                err_d  = 1'b0;
              end
            end
          end
          REG_COUNT:  if (!locked) count_d = write_data_i;
          REG_SECTOR: if (!locked) cur_d = write_data_i;
          REG_DMA:    if (!locked) dma_d = write_data_i;
          default:    be_d = 1'b1;
        endcase
      end
      OP_TICK: begin
        if (phase_q == PH_DELAY) begin
          if (delay_q != '0) begin
            delay_d = delay_q - 1'b1;
          end else if (range_bad) begin
            err_d   = 1'b1;
            busy_d  = 1'b0;
            phase_d = PH_IDLE;
            ip_d    = ien_q;
          end else begin
            eff_start = 1'b1;
            eff_sl    = count_q;
            eff_run   = dma_q;
            eff_words = '0;
          end
        end
        if (eff_start || locked) begin
          // One word move per tick, words then sectors ascending.
          words32 = 32'(eff_words);
          mv_d    = 1'b1;
          md_d    = wm_q;
          ma_d    = eff_run;
          ds_d    = cur_q;
          wi_d    = words32[6:0];
          phase_d = PH_XFER;
          run_d   = eff_run + 32'(WordBytes);
          sl_d    = eff_sl;
          words_d = eff_words + 1'b1;
          if (eff_words == WW'(SECTOR_WORDS - 1)) begin
            words_d = '0;
            cur_d   = cur_q + 1'b1;
            sl_d    = eff_sl - 1'b1;
            if (eff_sl == 32'd1) begin
              prev_d  = cur_q + 1'b1;
              busy_d  = 1'b0;
              phase_d = PH_IDLE;
              ip_d    = ien_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign span  = (cur_q >= prev_q) ? (cur_q - prev_q) : (prev_q - cur_q);
  assign trial = {rem_q, dvd_q[ProdWidth-1]};
  assign diff  = trial - {1'b0, cap_q};
  assign dsum  = {1'b0, dvd_q} + (ProdWidth + 1)'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= '0;
      base_q <= BaseDelayReset[15:0];
      seek_q <= SeekFactorReset[15:0];
      wm_q <= 1'b0; ien_q <= 1'b0; err_q <= 1'b0; busy_q <= 1'b0;
      count_q <= '0; cur_q <= '0; dma_q <= '0; prev_q <= '0;
      delay_q <= '0; sl_q <= '0; run_q <= '0; phase_q <= PH_IDLE; words_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_q  <= cfg_data_i;
          CFG_BASE:     base_q <= cfg_data_i[15:0];
          CFG_SEEK:     seek_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        wm_q <= wm_d; ien_q <= ien_d; err_q <= err_d; busy_q <= busy_d;
        count_q <= count_d; cur_q <= cur_d; dma_q <= dma_d; prev_q <= prev_d;
        delay_q <= delay_d; sl_q <= sl_d; run_q <= run_d; phase_q <= phase_d;
        words_q <= words_d;
      end else if (cmd_i.fin) begin
        // Saturate the seek delay to 32 bits.
        delay_q <= (dsum[ProdWidth:32] != '0) ? '1 : dsum[31:0];
        phase_q <= PH_DELAY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dvd_q <= span * seek_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        dvd_q <= {dvd_q[ProdWidth-2:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        dvd_q <= {dvd_q[ProdWidth-2:0], 1'b0};
      end
    end
    if (cmd_i.step) begin
      read_data_o       <= rd_d;
      bus_error_o       <= be_d;
      move_valid_o      <= mv_d;
      move_to_disk_o    <= md_d;
      memory_address_o  <= ma_d;
      disk_sector_o     <= ds_d;
      word_in_sector_o  <= wi_d;
      interrupt_pulse_o <= ip_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/dma_disk_controller_unit.sv @@
`default_nettype none
// Results are registered: each appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless the output stalls, except a start
// write that finds a disk, which occupies the block while the seek delay is formed
// by one multiply and a 48-step restoring divider (one quotient bit per cycle).
// Reset: asynchronous, active low; all but the result and divider registers reset.
module dma_disk_controller_unit #(
  parameter int unsigned SECTOR_WORDS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel; always ready.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // Request channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [2:0]  register_index_i,
  input  wire logic [31:0] write_data_i,
  // Result channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             bus_error_o,
  output logic             move_valid_o,
  output logic             move_to_disk_o,
  output logic [31:0]      memory_address_o,
  output logic [31:0]      disk_sector_o,
  output logic [6:0]       word_in_sector_o,
  output logic             interrupt_pulse_o
);
  import dmadc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // The controller sequences each request and the seek calculation after a start.
  dmadc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the register file, transfer counters and the divider.
  dmadc_dp #(
    .SECTOR_WORDS (SECTOR_WORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .register_index_i  (register_index_i),
    .write_data_i      (write_data_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .read_data_o       (read_data_o),
    .bus_error_o       (bus_error_o),
    .move_valid_o      (move_valid_o),
    .move_to_disk_o    (move_to_disk_o),
    .memory_address_o  (memory_address_o),
    .disk_sector_o     (disk_sector_o),
    .word_in_sector_o  (word_in_sector_o),
    .interrupt_pulse_o (interrupt_pulse_o)
  );

endmodule
`default_nettype wire

@@ test/tb_dma_disk_controller_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_dma_disk_controller_unit;
  import dmadc_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Inputs of the block, all known from time zero.
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic [1:0]  operation_i = '0;
  logic [2:0]  register_index_i = '0;
  logic [31:0] write_data_i = '0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o, in_ready_o, out_valid_o;
  logic [31:0] read_data_o, memory_address_o, disk_sector_o;
  logic        bus_error_o, move_valid_o, move_to_disk_o, interrupt_pulse_o;
  logic [6:0]  word_in_sector_o;

  dma_disk_controller_unit u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i, .register_index_i, .write_data_i,
    .out_valid_o, .out_ready_i, .read_data_o, .bus_error_o, .move_valid_o,
    .move_to_disk_o, .memory_address_o, .disk_sector_o, .word_in_sector_o,
    .interrupt_pulse_o
  );

  // One bus request as the host issues it.
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  idx;
    logic [31:0] data;
  } bus_req_t;

  // One response word from the controller.
  typedef struct packed {
    logic [31:0] rdata;
    logic        berr;
    logic        mv;
    logic        to_disk;
    logic [31:0] maddr;
    logic [31:0] sector;
    logic [6:0]  word;
    logic        irq;
  } bus_rsp_t;

  // Requests waiting to be driven; the configuration phases are separated by
  // a marker request, flagged in marker_queue and handled below.
  bus_req_t req_queue[$];
  // Configuration write attached to a phase boundary, one per marker.
  logic [1:0]  cfg_idx_queue[$];
  logic [31:0] cfg_val_queue[$];
  bit          marker_queue[$];
  bus_rsp_t    expected_rsp[$];

  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  // Controller model state, kept by the scoreboard.
  logic [31:0] m_capacity, m_base, m_seek;
  logic        m_wmode, m_ien, m_err, m_busy;
  logic [31:0] m_count, m_sector, m_dma, m_prev_end, m_delay, m_left, m_run;
  logic [1:0]  m_phase;
  logic [6:0]  m_words;

  function automatic logic [31:0] seek_ticks();
    logic [63:0] span, d;
    span = (m_sector >= m_prev_end) ? 64'(m_sector - m_prev_end)
                                    : 64'(m_prev_end - m_sector);
    d = 64'(m_base) + (span * 64'(m_seek)) / 64'(m_capacity);
    return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // Advances the model by one request and returns the response it predicts.
  function automatic bus_rsp_t controller_step(bus_req_t r);
    bus_rsp_t o;
    bit locked;
    o = '0;
    locked = (m_phase == PH_XFER);
    if (r.op == OP_READ) begin
      if (r.idx == REG_CTRL) o.rdata = {27'd0, m_busy, m_err, m_wmode, m_ien, 1'b0};
      else if (r.idx == REG_CAPACITY) o.rdata = m_capacity;
      else o.berr = 1'b1;
    end else if (r.op == OP_WRITE) begin
      case (r.idx)
        REG_CTRL: begin
          if (!locked) begin
            m_wmode = r.data[2];
            m_ien = r.data[1];
            if (r.data[0]) begin
              m_busy = 1'b1;
              m_err = 1'b0;
              if (m_capacity != 0) begin
                m_delay = seek_ticks();
                m_phase = PH_DELAY;
              end
            end
          end
        end
        REG_COUNT: if (!locked) m_count = r.data;
        REG_SECTOR: if (!locked) m_sector = r.data;
        REG_DMA: if (!locked) m_dma = r.data;
        default: o.berr = 1'b1;
      endcase
    end else if (r.op == OP_TICK) begin
      if (m_phase == PH_DELAY) begin
        if (m_delay != 0) begin
          m_delay--;
          return o;
        end
        if (m_capacity == 0 || m_count == 0 || m_sector >= m_capacity ||
            33'(m_sector) + 33'(m_count) > 33'(m_capacity)) begin
          m_err = 1'b1;
          m_busy = 1'b0;
          m_phase = PH_IDLE;
          o.irq = m_ien;
          return o;
        end
        m_phase = PH_XFER;
        m_left = m_count;
        m_words = '0;
        m_run = m_dma;
      end
      if (m_phase == PH_XFER) begin
        o.mv = 1'b1;
        o.to_disk = m_wmode;
        o.maddr = m_run;
        o.sector = m_sector;
        o.word = m_words;
        m_run += WordBytes;
        m_words++;
        if (m_words == 7'd0) begin
          m_sector++;
          m_left--;
          if (m_left == 0) begin
            m_prev_end = m_sector;
            m_busy = 1'b0;
            m_phase = PH_IDLE;
            o.irq = m_ien;
          end
        end
      end
    end
    return o;
  endfunction

  task automatic push_req(logic [1:0] op, logic [2:0] idx, logic [31:0] data);
    bus_req_t r;
    r.op = op;
    r.idx = idx;
    r.data = data;
    req_queue.push_back(r);
    marker_queue.push_back(1'b0);
  endtask

  // A configuration write happens between phases, once the block is drained.
  task automatic push_cfg(logic [1:0] idx, logic [31:0] val);
    req_queue.push_back('0);
    marker_queue.push_back(1'b1);
    cfg_idx_queue.push_back(idx);
    cfg_val_queue.push_back(val);
  endtask

  // A full transfer: program, start, then tick it through, amid occasional random requests.
  task automatic push_transfer(int unsigned ticks);
    push_req(OP_WRITE, REG_COUNT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2));
    push_req(OP_WRITE, REG_SECTOR, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20));
    push_req(OP_WRITE, REG_DMA, $urandom);
    push_req(OP_WRITE, REG_CTRL, {$urandom} | 32'd1);
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_req(2'($urandom_range(0, 3)), 3'($urandom), $urandom);
      else
        push_req(OP_TICK, 3'($urandom), $urandom);
    end
  endtask

  // Stimulus: directed corner cases first, then random phases with new settings.
  initial begin
    m_capacity = '0; m_base = BaseDelayReset; m_seek = SeekFactorReset;
    {m_wmode, m_ien, m_err, m_busy} = '0;
    {m_count, m_sector, m_dma, m_prev_end, m_delay, m_left, m_run} = '0;
    m_phase = PH_IDLE;
    m_words = '0;

    // Every register index read at reset, then illegal writes and an illegal op.
    for (int i = 0; i < 8; i++) push_req(OP_READ, 3'(i), '0);
    push_req(OP_WRITE, REG_CAPACITY, 32'hFFFF_FFFF);
    push_req(OP_WRITE, 3'd7, '0);
    push_req(2'd3, 3'd7, 32'hFFFF_FFFF);
    // Start with no disk: busy stays set.
    push_req(OP_WRITE, REG_CTRL, 32'h7);
    push_req(OP_READ, REG_CTRL, '0);
    push_req(OP_TICK, '0, '0);
    push_cfg(CFG_CAPACITY, 32'd16);
    push_cfg(CFG_BASE, 32'd0);
    push_cfg(CFG_SEEK, 32'd0);
    // Zero count gives an error at once; a good one-sector transfer follows.
    push_req(OP_WRITE, REG_COUNT, '0);
    push_req(OP_WRITE, REG_CTRL, 32'h3);
    push_req(OP_TICK, '0, '0);
    push_req(OP_READ, REG_CTRL, '0);
    push_req(OP_WRITE, REG_COUNT, 32'd1);
    push_req(OP_WRITE, REG_SECTOR, 32'd15);
    push_req(OP_WRITE, REG_DMA, 32'hFFFF_FFF8);
    push_req(OP_WRITE, REG_CTRL, 32'h7);
    // Restart while waiting, then writes locked out mid transfer.
    push_req(OP_WRITE, REG_CTRL, 32'h7);
    for (int i = 0; i < 3; i++) push_req(OP_TICK, '0, '0);
    push_req(OP_WRITE, REG_SECTOR, 32'd0);
    for (int i = 0; i < 130; i++) push_req(OP_TICK, '0, '0);

    // Random phases; the extremes of the settings among them.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          push_cfg(CFG_CAPACITY, 32'hFFFF_FFFF);
          push_cfg(CFG_BASE, 32'd65535);
          push_cfg(CFG_SEEK, 32'd65535);
        end
        1: begin
          push_cfg(CFG_CAPACITY, 32'd1);
          push_cfg(CFG_BASE, 32'd0);
          push_cfg(CFG_SEEK, 32'd65535);
        end
        default: begin
          push_cfg(CFG_CAPACITY, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 24));
          push_cfg(CFG_BASE, $urandom_range(0, 4));
          push_cfg(CFG_SEEK, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 8));
        end
      endcase
      push_transfer(ph < 2 ? 20 : $urandom_range(40, 220));
    end
    // A tail of noise.
    for (int i = 0; i < 60; i++) push_req(2'($urandom), 3'($urandom), $urandom);
  end

  // Driver: issues requests after a random gap, and performs configuration
  // writes at phase markers once every expected response has arrived.
  int in_gap = 0;
  int drain_wait = 0;
  bit cfg_busy = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
        cfg_busy = 1'b0;
      end else if (in_valid_i && in_ready_o) begin
        expected_rsp.push_back(controller_step(req_queue.pop_front()));
        void'(marker_queue.pop_front());
        in_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        // With no gap the next request follows straight away.
        if (in_gap == 0 && req_queue.size() != 0 && !marker_queue[0]) begin
          operation_i <= req_queue[0].op;
          register_index_i <= req_queue[0].idx;
          write_data_i <= req_queue[0].data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && !cfg_busy) begin
        if (req_queue.size() == 0) begin
          stim_done = 1'b1;
        end else if (marker_queue[0]) begin
          // The seek divider may still run after a start; let it settle.
          if (expected_rsp.size() != 0) drain_wait = 0;
          else if (drain_wait < 60) drain_wait++;
          else begin
            drain_wait = 0;
            void'(req_queue.pop_front());
            void'(marker_queue.pop_front());
            case (cfg_idx_queue[0])
              CFG_CAPACITY: m_capacity = cfg_val_queue[0];
              CFG_BASE: m_base = {16'd0, cfg_val_queue[0][15:0]};
              default: m_seek = {16'd0, cfg_val_queue[0][15:0]};
            endcase
            cfg_index_i <= cfg_idx_queue.pop_front();
            cfg_data_i <= cfg_val_queue.pop_front();
            cfg_valid_i <= 1'b1;
            cfg_busy = 1'b1;
          end
        end else if (in_gap > 0) begin
          in_gap--;
        end else begin
          operation_i <= req_queue[0].op;
          register_index_i <= req_queue[0].idx;
          write_data_i <= req_queue[0].data;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: random back-pressure, one long hold-off, and the field checks.
  int out_gap = 0;
  int rsp_count = 0;
  always @(posedge clk_i) begin
    bus_rsp_t got, exp_rsp;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {read_data_o, bus_error_o, move_valid_o, move_to_disk_o,
               memory_address_o, disk_sector_o, word_in_sector_o, interrupt_pulse_o};
        rsp_count++;
        if (expected_rsp.size() == 0) begin
          $error("unexpected response %h", got);
          errors++;
        end else begin
          exp_rsp = expected_rsp.pop_front();
          if (got.rdata !== exp_rsp.rdata) begin
            $error("read_data exp %h got %h", exp_rsp.rdata, got.rdata); errors++;
          end
          if (got.berr !== exp_rsp.berr) begin
            $error("bus_error exp %b got %b", exp_rsp.berr, got.berr); errors++;
          end
          if (got.mv !== exp_rsp.mv) begin
            $error("move_valid exp %b got %b", exp_rsp.mv, got.mv); errors++;
          end
          if (got.to_disk !== exp_rsp.to_disk) begin
            $error("move_to_disk exp %b got %b", exp_rsp.to_disk, got.to_disk); errors++;
          end
          if (got.maddr !== exp_rsp.maddr) begin
            $error("memory_address exp %h got %h", exp_rsp.maddr, got.maddr); errors++;
          end
          if (got.sector !== exp_rsp.sector) begin
            $error("disk_sector exp %h got %h", exp_rsp.sector, got.sector); errors++;
          end
          if (got.word !== exp_rsp.word) begin
            $error("word_in_sector exp %h got %h", exp_rsp.word, got.word); errors++;
          end
          if (got.irq !== exp_rsp.irq) begin
            $error("interrupt_pulse exp %b got %b", exp_rsp.irq, got.irq); errors++;
          end
        end
        // After the sixtieth response the receiver stalls long enough for the
        // block to fill and hold off its request side.
        out_gap = (rsp_count == 60) ? 80
                : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6));
        out_ready_i <= (out_gap == 0);
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= (out_gap == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && expected_rsp.size() == 0) && idle_cycles < 2000)
      @(posedge clk_i);
    if (idle_cycles >= 2000) begin
      $display("FAIL dma_disk_controller_unit");
    end else begin
      repeat (60) @(posedge clk_i);
      if (errors == 0 && expected_rsp.size() == 0) $display("PASS dma_disk_controller_unit");
      else $display("FAIL dma_disk_controller_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
